// ===== rtl/core/one_wire_rom_search_unit_macros.svh =====
// ----------------------------------------------------------------------------
// one_wire_rom_search_unit macros
// assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_ROM_SEARCH_UNIT_MACROS_SVH
`define ONE_WIRE_ROM_SEARCH_UNIT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define OWRS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("owrs same-cycle check failed");

// next-cycle implication, sampled on clock, off during reset
`define OWRS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("owrs next-cycle check failed");

`endif

// ===== rtl/core/owrs_pkg.sv =====
// ----------------------------------------------------------------------------
// owrs_pkg
// shared types and constants of the 1-wire rom search unit
// ----------------------------------------------------------------------------
package owrs_pkg;

   // bit position one past the last rom bit
   localparam logic [7:0] RomBitsEnd  = 8'd65;
   // positions below this lie in the family byte
   localparam logic [6:0] FamilyLimit = 7'd9;

   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BIT   = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_STARTED  = 3'd0,
      ST_CONTINUE = 3'd1,
      ST_FOUND    = 3'd2,
      ST_FAILED   = 3'd3,
      ST_IDLE     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_START,
      CMD_BIT,
      CMD_CLEAR
   } cmd_type;

   // classified request as it waits in the queue
   typedef struct packed {
      cmd_type cmd;
      logic    no_presence;
      logic    id_bit;
      logic    discrepancy;   // both slots read zero
      logic    abort;         // both slots read one
   } queue_entry_type;

endpackage

// ===== rtl/core/owrs_if.sv =====
// ----------------------------------------------------------------------------
// owrs channel interfaces
// valid/ready channels for requests and responses
// ----------------------------------------------------------------------------
interface owrs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic       no_presence;
   logic       id_bit;
   logic       complement_bit;

   modport source (output valid, output op, output no_presence, output id_bit,
                   output complement_bit, input ready);
   modport sink   (input valid, input op, input no_presence, input id_bit,
                   input complement_bit, output ready);
endinterface

interface owrs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        direction;
   logic [63:0] rom_code;
   logic [6:0]  discrepancy_out;
   logic [3:0]  family_discrepancy;
   logic        last_device_out;

   modport source (output valid, output status, output direction, output rom_code,
                   output discrepancy_out, output family_discrepancy,
                   output last_device_out, input ready);
   modport sink   (input valid, input status, input direction, input rom_code,
                   input discrepancy_out, input family_discrepancy,
                   input last_device_out, output ready);
endinterface

// ===== rtl/core/one_wire_rom_search_unit.sv =====
// ----------------------------------------------------------------------------
// one_wire_rom_search_unit
// rom search engine of a 1-wire bus master
// ----------------------------------------------------------------------------
// usage
//   req_if: one request per transfer; op start carries the presence sample,
//   op bit carries the two read slots, op clear drops all search state
//   rsp_if: exactly one response per request, in request order, with the
//   status, the direction to write and the search state after the update
// a taken request is written into the queue, then into the response register,
//   and is offered on rsp_if from that register
// throughput: one request per cycle while rsp_if takes each response; the back
//   end updates the search state once per request, which is the loop that sets the rate
// a two-entry queue sits between the front and the back end, so requests
//   keep flowing while a response waits in the output register
// receiver stall: the response holds steady, the queue fills, and req_if.ready
//   drops once two requests are waiting
// reset: synchronous, clears the rom code and all search state, empties the
//   queue and withdraws any pending response
// ----------------------------------------------------------------------------
module one_wire_rom_search_unit import owrs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   owrs_req_if.sink   req_if,
   owrs_rsp_if.source rsp_if
);

   // front to queue
   logic            push_valid;
   queue_entry_type push_entry;
   logic            queue_full;

   // queue to back end
   logic            q_valid;
   logic            q_pop;
   queue_entry_type q_entry;

   // classify incoming requests
   owrs_front u_front (
      .req        (req_if),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // decouple the request side from the response side
   owrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   // search state update and response register
   owrs_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .rsp     (rsp_if)
   );

endmodule

// ===== rtl/core/owrs_front.sv =====
// ----------------------------------------------------------------------------
// owrs_front
// accepts requests and classifies them into queue entries
// ----------------------------------------------------------------------------
module owrs_front import owrs_pkg::*; (
   owrs_req_if.sink        req,
   input  logic            queue_full,
   output logic            push_valid,
   output queue_entry_type push_entry
);

   assign req.ready  = !queue_full;
   assign push_valid = req.valid && !queue_full;

   always_comb begin
      push_entry.no_presence = req.no_presence;
      push_entry.id_bit      = req.id_bit;
      push_entry.discrepancy = !req.id_bit && !req.complement_bit;
      push_entry.abort       = req.id_bit && req.complement_bit;
      case (op_type'(req.op))
         OP_START: begin
            push_entry.cmd = CMD_START;
         end
         OP_BIT: begin
            push_entry.cmd = CMD_BIT;
         end
         OP_CLEAR: begin
            push_entry.cmd = CMD_CLEAR;
         end
         default: begin
            push_entry.cmd = CMD_NOP;
         end
      endcase
   end

endmodule

// ===== rtl/core/owrs_queue.sv =====
// ----------------------------------------------------------------------------
// owrs_queue
// short fifo between the front and the back
// ----------------------------------------------------------------------------
module owrs_queue import owrs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   input  queue_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output logic            pop_valid,
   output queue_entry_type pop_entry
);

   queue_entry_type       entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]  count_ff, count_in;

   assign full      = (count_ff == QueueCntW'(QueueDepth));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entry_ff[rd_ptr_ff];

   // pointers wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/owrs_back.sv =====
// ----------------------------------------------------------------------------
// owrs_back
// search state and its update, response output register
// ----------------------------------------------------------------------------
module owrs_back import owrs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  queue_entry_type q_entry,
   output logic            q_pop,
   owrs_rsp_if.source      rsp
);

   logic [63:0] rom_ff, rom_in;
   logic [6:0]  last_disc_ff, last_disc_in;
   logic [3:0]  fam_disc_ff, fam_disc_in;
   logic        last_dev_ff, last_dev_in;
   logic [6:0]  bit_pos_ff, bit_pos_in;
   logic [6:0]  last_zero_ff, last_zero_in;
   logic        searching_ff, searching_in;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff, status_in;
   logic        dir_ff, dir_in;

   logic [5:0]  idx;
   logic [7:0]  pos_inc;
   logic        dir;

   assign q_pop   = q_valid && (!rsp_valid_ff || rsp.ready);
   assign idx     = bit_pos_ff[5:0] - 6'd1;
   assign pos_inc = {1'b0, bit_pos_ff} + 8'd1;

   // direction: forced by the bus, else taken from the previous code below the last discrepancy, one at it, zero beyond
   always_comb begin
      if (!q_entry.discrepancy) begin
         dir = q_entry.id_bit;
      end else if (bit_pos_ff < last_disc_ff) begin
         dir = rom_ff[idx];
      end else begin
         dir = (bit_pos_ff == last_disc_ff);
      end
   end

   always_comb begin
      rom_in       = rom_ff;
      last_disc_in = last_disc_ff;
      fam_disc_in  = fam_disc_ff;
      last_dev_in  = last_dev_ff;
      bit_pos_in   = bit_pos_ff;
      last_zero_in = last_zero_ff;
      searching_in = searching_ff;
      status_in    = ST_IDLE;
      dir_in       = 1'b0;
      case (q_entry.cmd)
         CMD_START: begin
            searching_in = 1'b0;
            if (last_dev_ff || q_entry.no_presence) begin
               last_disc_in = '0;
               fam_disc_in  = '0;
               last_dev_in  = 1'b0;
               status_in    = ST_FAILED;
            end else begin
               searching_in = 1'b1;
               bit_pos_in   = 7'd1;
               last_zero_in = '0;
               status_in    = ST_STARTED;
            end
         end
         CMD_BIT: begin
            if (searching_ff && q_entry.abort) begin
               searching_in = 1'b0;
               last_disc_in = '0;
               fam_disc_in  = '0;
               last_dev_in  = 1'b0;
               status_in    = ST_FAILED;
            end else if (searching_ff) begin
               dir_in = dir;
               if (q_entry.discrepancy && !dir) begin
                  last_zero_in = bit_pos_ff;
                  if (bit_pos_ff < FamilyLimit) begin
                     fam_disc_in = bit_pos_ff[3:0];
                  end
               end
               rom_in[idx] = dir;
               bit_pos_in  = pos_inc[6:0];
               if (pos_inc >= RomBitsEnd) begin
                  searching_in = 1'b0;
                  last_disc_in = last_zero_in;
                  if (last_zero_in == '0) begin
                     last_dev_in = 1'b1;
                  end
                  if (rom_in[7:0] == 8'd0) begin
                     last_disc_in = '0;
                     fam_disc_in  = '0;
                     last_dev_in  = 1'b0;
                     status_in    = ST_FAILED;
                  end else begin
                     status_in    = ST_FOUND;
                  end
               end else begin
                  status_in = ST_CONTINUE;
               end
            end
         end
         CMD_CLEAR: begin
            last_disc_in = '0;
            fam_disc_in  = '0;
            last_dev_in  = 1'b0;
            searching_in = 1'b0;
            bit_pos_in   = '0;
            last_zero_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = q_pop || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_ff       <= '0;
         last_disc_ff <= '0;
         fam_disc_ff  <= '0;
         last_dev_ff  <= 1'b0;
         bit_pos_ff   <= '0;
         last_zero_ff <= '0;
         searching_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            rom_ff       <= rom_in;
            last_disc_ff <= last_disc_in;
            fam_disc_ff  <= fam_disc_in;
            last_dev_ff  <= last_dev_in;
            bit_pos_ff   <= bit_pos_in;
            last_zero_ff <= last_zero_in;
            searching_ff <= searching_in;
         end
      end
   end

   // response payload, loaded with the state it reports
   always_ff @(posedge clock) begin
      if (q_pop) begin
         status_ff <= status_in;
         dir_ff    <= dir_in;
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.status             = 3'(status_ff);
   assign rsp.direction          = dir_ff;
   assign rsp.rom_code           = rom_ff;
   assign rsp.discrepancy_out    = last_disc_ff;
   assign rsp.family_discrepancy = fam_disc_ff;
   assign rsp.last_device_out    = last_dev_ff;

endmodule

// ===== rtl/core/owrs_checker.sv =====
// ----------------------------------------------------------------------------
// owrs_checker
// port-level checks of the rom search unit, bound to the top level
// ----------------------------------------------------------------------------
`include "one_wire_rom_search_unit_macros.svh"

module owrs_checker import owrs_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_family_byte,
   input logic [6:0] rsp_discrepancy_out,
   input logic [3:0] rsp_family_discrepancy,
   input logic       rsp_last_device_out
);

   // a stalled response keeps its status
   `OWRS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))

   // a found code never has a zero family byte
   `OWRS_ASSERT_NOW(a_found_family, rsp_valid && rsp_status == ST_FOUND, rsp_family_byte != 8'd0)

   // last device flag follows a zero discrepancy at the end of a search
   `OWRS_ASSERT_NOW(a_found_last, rsp_valid && rsp_status == ST_FOUND, rsp_last_device_out == (rsp_discrepancy_out == 7'd0))

   // a failed search leaves no discrepancy state behind
   `OWRS_ASSERT_NOW(a_failed_clear, rsp_valid && rsp_status == ST_FAILED, rsp_discrepancy_out == 7'd0 && rsp_family_discrepancy == 4'd0 && !rsp_last_device_out)

   // family discrepancy stays inside the family byte, the last discrepancy inside the code
   `OWRS_ASSERT_NOW(a_family_range, rsp_valid, rsp_family_discrepancy <= 4'd8 && rsp_discrepancy_out <= 7'd64)

endmodule

bind one_wire_rom_search_unit owrs_checker u_owrs_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_if.valid),
   .rsp_ready              (rsp_if.ready),
   .rsp_status             (rsp_if.status),
   .rsp_family_byte        (rsp_if.rom_code[7:0]),
   .rsp_discrepancy_out    (rsp_if.discrepancy_out),
   .rsp_family_discrepancy (rsp_if.family_discrepancy),
   .rsp_last_device_out    (rsp_if.last_device_out)
);

// ===== tb/sv/tb_one_wire_rom_search_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_one_wire_rom_search_unit
// drives rom search requests and checks every response against an in-bench
// copy of the search state; a small model of devices on the bus answers the
// read slots, so whole searches enumerate several devices in turn
// ----------------------------------------------------------------------------
module tb_one_wire_rom_search_unit;
   import owrs_pkg::*;

   // op code that the unit leaves unused
   localparam logic [1:0] OpUnused = 2'd3;

   localparam int IdlePercent = 29;
   localparam int RandomItems = 950;
   localparam int CycleLimit  = 400000;
   localparam int PrintLimit  = 100;

   // one expected response
   typedef struct packed {
      status_type  status;
      logic        direction;
      logic [63:0] rom_code;
      logic [6:0]  disc;
      logic [3:0]  family;
      logic        last_device;
   } rom_search_result_type;

   logic clock;
   logic reset;

   owrs_req_if req_if ();
   owrs_rsp_if rsp_if ();

   one_wire_rom_search_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // own copy of the search state, updated at each accepted request
   logic [63:0] model_rom;
   logic [6:0]  model_last_disc;
   logic [3:0]  model_family;
   logic        model_last_dev;
   logic [6:0]  model_bit_pos;
   logic [6:0]  model_last_zero;
   logic        model_searching;

   // responses still owed by the unit, oldest first
   rom_search_result_type pending_results[$];

   // rom codes of the devices currently hanging on the modeled bus
   logic [63:0] bus_devices[$];

   int mismatch_count = 0;
   int sent_items     = 0;
   int cycle_count    = 0;
   // when set neither side idles
   bit steady_flow    = 1'b0;

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // ------------------------------------------------------------------------
   // search state prediction
   // ------------------------------------------------------------------------
   function automatic void clear_model_discrepancies();
      model_last_disc = 7'd0;
      model_last_dev  = 1'b0;
      model_family    = 4'd0;
   endfunction

   function automatic void reset_search_model();
      model_rom       = 64'd0;
      clear_model_discrepancies();
      model_bit_pos   = 7'd0;
      model_last_zero = 7'd0;
      model_searching = 1'b0;
   endfunction

   // applies one request to the state and returns the response it causes
   function automatic rom_search_result_type advance_search_state(
         input logic [1:0] op, input logic no_presence,
         input logic id_bit, input logic cmp_bit);
      rom_search_result_type outcome;
      logic [5:0]            slot;
      logic [7:0]            next_pos;
      logic                  dir;
      outcome.status = ST_IDLE;
      dir = 1'b0;
      case (op)
         OP_START: begin
            // a running search is always dropped
            model_searching = 1'b0;
            if (model_last_dev || no_presence) begin
               clear_model_discrepancies();
               outcome.status = ST_FAILED;
            end else begin
               model_searching = 1'b1;
               model_bit_pos   = 7'd1;
               model_last_zero = 7'd0;
               outcome.status  = ST_STARTED;
            end
         end
         OP_BIT: begin
            if (model_searching && id_bit && cmp_bit) begin
               // nobody drove the line low in either slot
               model_searching = 1'b0;
               clear_model_discrepancies();
               outcome.status = ST_FAILED;
            end else if (model_searching) begin
               slot = 6'(model_bit_pos - 7'd1);
               if (id_bit != cmp_bit) begin
                  dir = id_bit;
               end else begin
                  // discrepancy: follow the last code below the last branch,
                  // take one at it, zero beyond it
                  if (model_bit_pos < model_last_disc) begin
                     dir = model_rom[slot];
                  end else begin
                     dir = (model_bit_pos == model_last_disc);
                  end
                  if (!dir) begin
                     model_last_zero = model_bit_pos;
                     if (model_bit_pos < FamilyLimit) begin
                        model_family = model_bit_pos[3:0];
                     end
                  end
               end
               model_rom[slot] = dir;
               next_pos = {1'b0, model_bit_pos} + 8'd1;
               model_bit_pos = next_pos[6:0];
               if (next_pos >= RomBitsEnd) begin
                  model_searching = 1'b0;
                  model_last_disc = model_last_zero;
                  if (model_last_disc == 7'd0) begin
                     model_last_dev = 1'b1;
                  end
                  // a zero family byte means the code is junk
                  if (model_rom[7:0] == 8'd0) begin
                     clear_model_discrepancies();
                     outcome.status = ST_FAILED;
                  end else begin
                     outcome.status = ST_FOUND;
                  end
               end else begin
                  outcome.status = ST_CONTINUE;
               end
            end
         end
         OP_CLEAR: begin
            clear_model_discrepancies();
            model_searching = 1'b0;
            model_bit_pos   = 7'd0;
            model_last_zero = 7'd0;
         end
         default: begin
            // unused op leaves everything alone
         end
      endcase
      outcome.direction   = dir;
      outcome.rom_code    = model_rom;
      outcome.disc        = model_last_disc;
      outcome.family      = model_family;
      outcome.last_device = model_last_dev;
      return outcome;
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   // one request transfer; the prediction is made at the accepting edge
   task automatic send_item(input logic [1:0] op, input logic no_presence,
                            input logic id_bit, input logic cmp_bit,
                            output rom_search_result_type expected);
      @(negedge clock);
      while (!steady_flow && $urandom_range(99) < IdlePercent) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.op             <= op;
      req_if.no_presence    <= no_presence;
      req_if.id_bit         <= id_bit;
      req_if.complement_bit <= cmp_bit;
      do @(posedge clock); while (!req_if.ready);
      expected = advance_search_state(op, no_presence, id_bit, cmp_bit);
      pending_results.push_back(expected);
      sent_items++;
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------
   // random stalls on the response channel
   always @(negedge clock) begin
      rsp_if.ready <= steady_flow || ($urandom_range(99) >= IdlePercent);
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PrintLimit) begin
         $display("mismatch at %0t ns: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   // compares each response transfer with the oldest expectation, and
   // guards the run against a hang
   always @(posedge clock) begin : check_responses
      rom_search_result_type exp;
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL one_wire_rom_search_unit");
         $finish;
      end else if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response with none expected, status %0d",
                                      rsp_if.status));
         end else begin
            exp = pending_results.pop_front();
            if (rsp_if.status !== exp.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_if.status, exp.status));
            if (rsp_if.direction !== exp.direction)
               report_mismatch($sformatf("direction %0b, expected %0b",
                                         rsp_if.direction, exp.direction));
            if (rsp_if.rom_code !== exp.rom_code)
               report_mismatch($sformatf("rom_code %h, expected %h",
                                         rsp_if.rom_code, exp.rom_code));
            if (rsp_if.discrepancy_out !== exp.disc)
               report_mismatch($sformatf("discrepancy_out %0d, expected %0d",
                                         rsp_if.discrepancy_out, exp.disc));
            if (rsp_if.family_discrepancy !== exp.family)
               report_mismatch($sformatf("family_discrepancy %0d, expected %0d",
                                         rsp_if.family_discrepancy, exp.family));
            if (rsp_if.last_device_out !== exp.last_device)
               report_mismatch($sformatf("last_device_out %0b, expected %0b",
                                         rsp_if.last_device_out, exp.last_device));
         end
      end
   end

   // ------------------------------------------------------------------------
   // modeled bus
   // ------------------------------------------------------------------------
   // new population; later devices often differ from the one before in a
   // few bits only, so discrepancies fall deep in the code and in the family
   task automatic build_device_set(input int count, input bit zero_family);
      logic [63:0] code;
      int          flip;
      bus_devices.delete();
      for (int i = 0; i < count; i++) begin
         if (i > 0 && $urandom_range(1) == 1) begin
            code = bus_devices[i - 1];
            repeat ($urandom_range(1, 3)) begin
               // lean toward the family byte now and then
               flip = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(63);
               code[flip] = ~code[flip];
            end
         end else begin
            code = {$urandom, $urandom};
         end
         if (zero_family && i == 0) begin
            code[7:0] = 8'h00;
         end
         bus_devices.push_back(code);
      end
   endtask

   // one search pass: start, then the 64 read slot pairs as the devices
   // still in the running would pull the line; finished when start fails
   task automatic run_search(output bit finished);
      rom_search_result_type res;
      bit                    alive[$];
      logic                  id_bit;
      logic                  cmp_bit;
      finished = 1'b0;
      send_item(OP_START, bus_devices.size() == 0, 1'($urandom_range(1)),
                1'($urandom_range(1)), res);
      if (res.status != ST_STARTED) begin
         finished = 1'b1;
         return;
      end
      foreach (bus_devices[d]) alive.push_back(1'b1);
      for (int b = 0; b < 64; b++) begin
         // wired-and of the bit and of its complement over the live devices
         id_bit  = 1'b1;
         cmp_bit = 1'b1;
         foreach (bus_devices[d]) begin
            if (alive[d]) begin
               id_bit  &= bus_devices[d][b];
               cmp_bit &= ~bus_devices[d][b];
            end
         end
         // rare glitch on the line
         if ($urandom_range(199) == 0) begin
            {id_bit, cmp_bit} = 2'($urandom_range(3));
         end
         send_item(OP_BIT, 1'($urandom_range(1)), id_bit, cmp_bit, res);
         if (res.status == ST_FAILED) return;
         foreach (bus_devices[d]) begin
            if (bus_devices[d][b] != res.direction) alive[d] = 1'b0;
         end
         // search given up half way now and then
         if ($urandom_range(299) == 0) return;
      end
   endtask

   // enumerates a fresh population until start reports no more devices, at most count + 3 searches
   task automatic enumerate_bus(input int count, input bit zero_family);
      rom_search_result_type res;
      bit                    finished;
      build_device_set(count, zero_family);
      if ($urandom_range(9) != 0) begin
         send_item(OP_CLEAR, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), res);
      end
      for (int s = 0; s < count + 3; s++) begin
         run_search(finished);
         if (finished) break;
      end
   endtask

   task automatic send_noise(input int count);
      rom_search_result_type res;
      repeat (count) begin
         send_item(2'($urandom_range(3)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)), res);
      end
   endtask

   // start with a few random pairs, then cut off by abort, restart or clear
   task automatic send_broken_search();
      rom_search_result_type res;
      logic [1:0]            ending;
      send_item(OP_START, 1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)), res);
      repeat ($urandom_range(1, 12)) begin
         send_item(OP_BIT, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, res);
      end
      ending = 2'($urandom_range(2));
      if (ending == 2'd0) send_item(OP_BIT, 1'b0, 1'b1, 1'b1, res);
      else if (ending == 2'd1) send_item(OP_START, 1'b0, 1'b0, 1'b0, res);
      else send_item(OP_CLEAR, 1'b0, 1'b0, 1'b0, res);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // pairs with no search running, the unused op, clear from idle
   task automatic test_ignored_items();
      rom_search_result_type res;
      send_item(OP_BIT, 1'b0, 1'b0, 1'b0, res);
      send_item(OP_BIT, 1'b1, 1'b1, 1'b1, res);
      send_item(OP_BIT, 1'b0, 1'b1, 1'b0, res);
      send_item(OpUnused, 1'b1, 1'b1, 1'b1, res);
      send_item(OP_CLEAR, 1'b1, 1'b1, 1'b1, res);
   endtask

   // no presence, normal start, restart while a search runs
   task automatic test_start_outcomes();
      rom_search_result_type res;
      send_item(OP_START, 1'b1, 1'b1, 1'b1, res);
      send_item(OP_START, 1'b0, 1'b0, 1'b0, res);
      send_item(OP_BIT, 1'b0, 1'b0, 1'b1, res);
      send_item(OP_START, 1'b0, 1'b1, 1'b0, res);
   endtask

   // each pair kind, abort on one-one, unused op and clear mid search
   task automatic test_bit_pairs();
      rom_search_result_type res;
      send_item(OP_BIT, 1'b0, 1'b1, 1'b0, res);
      send_item(OP_BIT, 1'b1, 1'b0, 1'b1, res);
      send_item(OP_BIT, 1'b0, 1'b0, 1'b0, res);
      send_item(OpUnused, 1'b0, 1'b0, 1'b0, res);
      send_item(OP_BIT, 1'b1, 1'b0, 1'b0, res);
      send_item(OP_BIT, 1'b0, 1'b1, 1'b1, res);
      send_item(OP_BIT, 1'b0, 1'b0, 1'b0, res);
      send_item(OP_START, 1'b0, 1'b0, 1'b0, res);
      send_item(OP_BIT, 1'b0, 1'b0, 1'b0, res);
      send_item(OP_CLEAR, 1'b0, 1'b0, 1'b0, res);
      send_item(OP_BIT, 1'b0, 1'b1, 1'b0, res);
   endtask

   // sender holds off until the unit has answered everything
   task automatic test_drain_pause();
      rom_search_result_type res;
      // take the last request off the channel before waiting
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      send_item(OP_START, 1'b0, 1'b0, 1'b0, res);
      send_item(OP_BIT, 1'b0, 1'b0, 1'b0, res);
   endtask

   // whole searches over random device populations mixed with noise
   task automatic test_bus_enumeration();
      int target;
      target = sent_items + RandomItems;
      // a lone device with a zero family byte never counts as found
      enumerate_bus(1, 1'b1);
      // a stretch with no idling on either side
      steady_flow = 1'b1;
      enumerate_bus(3, 1'b0);
      steady_flow = 1'b0;
      while (sent_items < target) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5:
               enumerate_bus($urandom_range(1, 3), $urandom_range(9) == 0);
            6: enumerate_bus(0, 1'b0);
            7: send_noise($urandom_range(1, 8));
            default: send_broken_search();
         endcase
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.op             = OP_START;
      req_if.no_presence    = 1'b0;
      req_if.id_bit         = 1'b0;
      req_if.complement_bit = 1'b0;
      rsp_if.ready          = 1'b0;
      reset_search_model();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_ignored_items();
      test_start_outcomes();
      test_bit_pairs();
      test_drain_pause();
      test_bus_enumeration();

      @(negedge clock);
      req_if.valid <= 1'b0;
      // the cycle limit catches a response that never comes
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS one_wire_rom_search_unit");
      end else begin
         $display("FAIL one_wire_rom_search_unit");
      end
      $finish;
   end

endmodule
